/* design/ssa_pkg.sv */
// Shared widths, register indexes, reset values and state types of the segment averager.
`default_nettype none

package ssa_pkg;

    // Fixed field widths
    localparam int MAG_W      = 16;
    localparam int AVG_W      = 16;
    localparam int IDX_W      = 6;
    localparam int BIN_CFG_W  = 13;
    localparam int SEG_CFG_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Depth of the segment record queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd1;

    // Register reset values
    localparam logic [BIN_CFG_W-1:0] BIN_CFG_RESET = 13'd1024;
    localparam logic [SEG_CFG_W-1:0] SEG_CFG_RESET = 7'd64;

    typedef enum logic [1:0] {
        F_SETUP,
        F_DIVIDE,
        F_IDLE,
        F_FLUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_HOLD
    } back_state_t;

endpackage

`default_nettype wire

/* design/ssa_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module ssa_divider import ssa_pkg::*; #(
    parameter int QW = 16,
    parameter int VW = 13
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [VW-1:0] divisor,
    input  wire logic [VW-1:0] rem_init,
    input  wire logic [QW-1:0] dividend,
    output logic               done,
    output logic [QW-1:0]      quotient,
    output logic [VW-1:0]      remainder
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [VW-1:0]    rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [VW-1:0]    dsr_reg;

    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             step_bit;
    logic [VW-1:0]    step_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, quo_reg[QW-1]};
        diff     = trial - {1'b0, dsr_reg};
        step_bit = ~diff[VW];
        step_rem = step_bit ? diff[VW-1:0] : trial[VW-1:0];
    end

    // Step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(QW);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= step_rem;
            quo_reg <= {quo_reg[QW-2:0], step_bit};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* design/ssa_queue.sv */
// Small FIFO of segment records between the front and back parts.
`default_nettype none

module ssa_queue import ssa_pkg::*; #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)      count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* design/ssa_front.sv */
// Front part: registers, bin intake and segment boundary tracking; emits one record per segment.
`default_nettype none

module ssa_front import ssa_pkg::*; #(
    parameter int MAX_BINS     = 4096,
    parameter int MAX_SEGMENTS = 64,
    parameter int REC_W        = IDX_W + 2 * $clog2(MAX_BINS + 1) + MAG_W + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [MAG_W-1:0]      s_magnitude,
    output logic                       rec_push,
    output logic [REC_W-1:0]           rec_data,
    input  wire logic                  rec_full
);

    localparam int BIN_W = $clog2(MAX_BINS + 1);
    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
    localparam int SUM_W = MAG_W + BIN_W;

    front_state_t state_reg, state_next;

    logic [BIN_CFG_W-1:0] bin_cfg_reg;
    logic [SEG_CFG_W-1:0] seg_cfg_reg;

    logic [BIN_W-1:0] n_reg, n_next;
    logic [SEG_W-1:0] s_reg, s_next;
    logic [BIN_W-1:0] q_reg, q_next;
    logic [SEG_W-1:0] r_reg, r_next;
    logic [BIN_W-1:0] pos_reg, pos_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [BIN_W-1:0] seg_start_reg, seg_start_next;
    logic [BIN_W-1:0] seg_end_reg, seg_end_next;
    logic [SEG_W-1:0] rem_reg, rem_next;

    logic [BIN_W-1:0] n_eff;
    logic [SEG_W-1:0] s_eff;
    logic             cfg_hit;
    logic             s_accept;
    logic [BIN_W-1:0] pos_inc;
    logic [BIN_W-1:0] flush_len;
    logic [SEG_W:0]   rem_sum;
    logic             rem_wrap;
    logic [SEG_W-1:0] rem_step;
    logic [BIN_W:0]   end_step;
    logic [SEG_W:0]   seg_inc;
    logic             flush_last;
    logic             frame_done;
    logic             div_start;
    logic             div_done;
    logic [BIN_W-1:0] div_quo;
    logic [SEG_W-1:0] div_rem;

    // Register writes; indexes beyond the list are dropped
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid
                       && (cfg_index == REG_BIN_COUNT || cfg_index == REG_SEGMENT_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_cfg_reg <= BIN_CFG_RESET;
            seg_cfg_reg <= SEG_CFG_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_BIN_COUNT)     bin_cfg_reg <= cfg_data[BIN_CFG_W-1:0];
            if (cfg_index == REG_SEGMENT_COUNT) seg_cfg_reg <= cfg_data[SEG_CFG_W-1:0];
        end
    end

    // Clamp register values to the supported range
    always_comb begin
        if (bin_cfg_reg == '0)                n_eff = BIN_W'(1);
        else if (32'(bin_cfg_reg) > MAX_BINS) n_eff = BIN_W'(MAX_BINS);
        else                                  n_eff = BIN_W'(bin_cfg_reg);
        if (seg_cfg_reg == '0)                    s_eff = SEG_W'(1);
        else if (32'(seg_cfg_reg) > MAX_SEGMENTS) s_eff = SEG_W'(MAX_SEGMENTS);
        else                                      s_eff = SEG_W'(seg_cfg_reg);
    end

    // Quotient and remainder of bins over segments, once per setup
    ssa_divider #(
        .QW (BIN_W),
        .VW (SEG_W)
    ) u_cfg_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .divisor   (s_eff),
        .rem_init  ('0),
        .dividend  (n_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Segment boundary arithmetic
    always_comb begin
        s_accept   = s_valid && s_ready;
        pos_inc    = pos_reg + BIN_W'(1);
        flush_len  = seg_end_reg - seg_start_reg;
        rem_sum    = {1'b0, rem_reg} + {1'b0, r_reg};
        rem_wrap   = (rem_sum >= {1'b0, s_reg});
        rem_step   = rem_wrap ? SEG_W'(rem_sum - {1'b0, s_reg}) : rem_sum[SEG_W-1:0];
        end_step   = {1'b0, seg_end_reg} + {1'b0, q_reg} + (BIN_W + 1)'(rem_wrap);
        seg_inc    = {1'b0, seg_reg} + (SEG_W + 1)'(1);
        flush_last = !((seg_inc < {1'b0, s_reg}) && (end_step <= {1'b0, pos_reg}));
        frame_done = (pos_reg == n_reg);
        rec_data   = {IDX_W'(seg_reg), sum_reg, flush_len, flush_last};
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_SETUP:  state_next = F_DIVIDE;
            F_DIVIDE: if (div_done) state_next = F_IDLE;
            F_IDLE:   if (s_accept && seg_end_reg <= pos_inc) state_next = F_FLUSH;
            F_FLUSH:  if (!rec_full && flush_last) state_next = F_IDLE;
            default:  state_next = F_SETUP;
        endcase
        if (cfg_hit) state_next = F_SETUP;
    end

    // Outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        rec_push  = 1'b0;
        case (state_reg)
            F_SETUP:  div_start = 1'b1;
            F_DIVIDE: ;
            F_IDLE:   s_ready = 1'b1;
            F_FLUSH:  rec_push = !rec_full;
            default:  ;
        endcase
    end

    // Frame counters
    always_comb begin
        n_next         = n_reg;
        s_next         = s_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        pos_next       = pos_reg;
        seg_next       = seg_reg;
        sum_next       = sum_reg;
        seg_start_next = seg_start_reg;
        seg_end_next   = seg_end_reg;
        rem_next       = rem_reg;
        case (state_reg)
            F_SETUP: begin
                n_next = n_eff;
                s_next = s_eff;
            end
            F_DIVIDE: begin
                if (div_done) begin
                    q_next         = div_quo;
                    r_next         = div_rem;
                    pos_next       = '0;
                    seg_next       = '0;
                    sum_next       = '0;
                    seg_start_next = '0;
                    seg_end_next   = div_quo;
                    rem_next       = div_rem;
                end
            end
            F_IDLE: begin
                if (s_accept) begin
                    sum_next = sum_reg + SUM_W'(s_magnitude);
                    pos_next = pos_inc;
                end
            end
            F_FLUSH: begin
                if (!rec_full) begin
                    // empty segments leave the sum for the segment that holds the bin
                    if (flush_len != '0) sum_next = '0;
                    seg_next       = seg_inc[SEG_W-1:0];
                    seg_start_next = seg_end_reg;
                    seg_end_next   = end_step[BIN_W-1:0];
                    rem_next       = rem_step;
                    if (flush_last && frame_done) begin
                        pos_next       = '0;
                        seg_next       = '0;
                        sum_next       = '0;
                        seg_start_next = '0;
                        seg_end_next   = q_reg;
                        rem_next       = r_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_SETUP;
            pos_reg       <= '0;
            seg_reg       <= '0;
            sum_reg       <= '0;
            seg_start_reg <= '0;
            seg_end_reg   <= '0;
            rem_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            seg_reg       <= seg_next;
            sum_reg       <= sum_next;
            seg_start_reg <= seg_start_next;
            seg_end_reg   <= seg_end_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg <= n_next;
        s_reg <= s_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

endmodule

`default_nettype wire

/* design/ssa_back.sv */
// Back part: divides the sum of each segment of two or more bins by its length and drives the result register.
`default_nettype none

module ssa_back import ssa_pkg::*; #(
    parameter int MAX_BINS = 4096,
    parameter int REC_W    = IDX_W + 2 * $clog2(MAX_BINS + 1) + MAG_W + 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rec_valid,
    input  wire logic [REC_W-1:0] rec_data,
    output logic                  rec_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [IDX_W-1:0]      m_segment_index,
    output logic [AVG_W-1:0]      m_average,
    output logic                  m_run_end
);

    localparam int BIN_W = $clog2(MAX_BINS + 1);
    localparam int SUM_W = MAG_W + BIN_W;

    back_state_t state_reg, state_next;

    logic [IDX_W-1:0] idx_reg;
    logic             last_reg;
    logic [AVG_W-1:0] avg_reg;
    logic             m_valid_reg;
    logic [IDX_W-1:0] m_idx_reg;
    logic [AVG_W-1:0] m_avg_reg;
    logic             m_last_reg;

    logic [IDX_W-1:0] rec_idx;
    logic [SUM_W-1:0] rec_sum;
    logic [BIN_W-1:0] rec_len;
    logic             rec_last;
    logic             take_short;
    logic             out_free;
    logic             can_take;
    logic             div_start;
    logic             div_done;
    logic [AVG_W-1:0] div_quo;
    logic             out_load;

    // Record fields
    always_comb begin
        rec_idx    = rec_data[REC_W-1 -: IDX_W];
        rec_sum    = rec_data[BIN_W+1 +: SUM_W];
        rec_len    = rec_data[1 +: BIN_W];
        rec_last   = rec_data[0];
        take_short = (rec_len <= BIN_W'(1));
        out_free   = !m_valid_reg || m_ready;
        can_take   = rec_valid && (state_reg == B_IDLE || (state_reg == B_HOLD && out_free));
    end

    // Mean of a segment; the sum's upper part is below the length, so 16 steps suffice
    ssa_divider #(
        .QW (AVG_W),
        .VW (BIN_W)
    ) u_avg_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .divisor   (rec_len),
        .rem_init  (rec_sum[SUM_W-1:AVG_W]),
        .dividend  (rec_sum[AVG_W-1:0]),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder ()
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (rec_valid) state_next = take_short ? B_HOLD : B_DIV;
            end
            B_DIV: begin
                if (div_done) state_next = B_HOLD;
            end
            B_HOLD: begin
                if (out_free) begin
                    if (rec_valid) state_next = take_short ? B_HOLD : B_DIV;
                    else           state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        rec_pop   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            B_IDLE: begin
                rec_pop   = can_take;
                div_start = can_take && !take_short;
            end
            B_DIV: ;
            B_HOLD: begin
                out_load  = out_free;
                rec_pop   = can_take;
                div_start = can_take && !take_short;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Result payload; empty segments give zero, single-bin segments their bin
    always_ff @(posedge aclk) begin
        if (can_take) begin
            idx_reg  <= rec_idx;
            last_reg <= rec_last;
            if (rec_len == '0)   avg_reg <= '0;
            else if (take_short) avg_reg <= rec_sum[AVG_W-1:0];
        end else if (state_reg == B_DIV && div_done) begin
            avg_reg <= div_quo;
        end
        if (out_load) begin
            m_idx_reg  <= idx_reg;
            m_avg_reg  <= avg_reg;
            m_last_reg <= last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_segment_index = m_idx_reg;
    assign m_average       = m_avg_reg;
    assign m_run_end       = m_last_reg;

endmodule

`default_nettype wire

/* design/spectrum_segment_averager_unit.sv */
// Spectrum segment averager: front intake, record queue and dividing back end.
//
// Usage: magnitudes of one frame enter on the s_ channel, one bin per item. For each
// segment of the frame one item leaves on the m_ channel, in segment order, with the
// segment index, the truncated mean of its bins (0 for an empty segment) and run_end
// set on the last result caused by one input bin. Both channels are valid/ready.
// Throughput: one bin per cycle inside a segment; a bin that closes segments holds
// s_ready low while it emits one record per closed segment into the queue. The back
// end works through each segment of two or more bins bit by bit (16 quotient bits,
// one a cycle) and takes no new record until its quotient is done, so short
// segments back up through the four-entry record queue into the front. A segment
// of at most one bin skips the divider.
// Reset and register writes: the cfg channel is always ready; a write to bin_count
// or segment_count drops the frame in progress, and s_ready stays low while bins
// over segments is divided. The same setup runs after reset. A stalled receiver
// fills the result register, then the queue, and finally lowers s_ready; nothing
// is dropped.
`default_nettype none

module spectrum_segment_averager_unit import ssa_pkg::*; #(
    parameter int MAX_BINS     = 4096,
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [MAG_W-1:0]      s_magnitude,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [IDX_W-1:0]           m_segment_index,
    output logic [AVG_W-1:0]           m_average,
    output logic                       m_run_end
);

    localparam int BIN_W = $clog2(MAX_BINS + 1);
    localparam int REC_W = IDX_W + (MAG_W + BIN_W) + BIN_W + 1;

    logic             rec_push;
    logic [REC_W-1:0] rec_in;
    logic             rec_full;
    logic             rec_pop;
    logic [REC_W-1:0] rec_out;
    logic             rec_empty;

    ssa_front #(
        .MAX_BINS     (MAX_BINS),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .REC_W        (REC_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_magnitude (s_magnitude),
        .rec_push    (rec_push),
        .rec_data    (rec_in),
        .rec_full    (rec_full)
    );

    ssa_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (rec_in),
        .full      (rec_full),
        .pop       (rec_pop),
        .pop_data  (rec_out),
        .empty     (rec_empty)
    );

    ssa_back #(
        .MAX_BINS (MAX_BINS),
        .REC_W    (REC_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rec_valid       (!rec_empty),
        .rec_data        (rec_out),
        .rec_pop         (rec_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_segment_index (m_segment_index),
        .m_average       (m_average),
        .m_run_end       (m_run_end)
    );

endmodule

`default_nettype wire
